/* rtl/kmst_pkg.sv */
// Shared types and constants of the union-find spanning tree engine.
// Depends on nothing; the RTL files refer to it by scoped names, the testbench imports it.
package kmst_pkg;

  localparam int unsigned NodeW       = 10;    // width of an endpoint index
  localparam int unsigned NodeCountW  = 11;    // width of the node count register
  localparam int unsigned CostW       = 16;    // width of an edge cost
  localparam int unsigned WeightW     = 32;    // width of the tree weight total
  localparam int unsigned RankW       = 4;     // width of a rank
  localparam int unsigned MaxUsedNodes    = 1024;  // highest node count ever in use
  localparam int unsigned MaxNodesDefault = 1024;

  // Encoding of the action field.
  localparam logic ActClear = 1'b0;
  localparam logic ActEdge  = 1'b1;

  typedef enum logic [3:0] {
    KMST_INIT,   // clearing pass after reset, no result
    KMST_IDLE,   // waiting for an input transfer
    KMST_CLEAR,  // clearing pass of a clear action
    KMST_FIND,   // walking the parent chain toward the root
    KMST_COMP,   // walking the chain again, pointing each node at the root
    KMST_NEXT,   // switching from the first endpoint to the second
    KMST_LINK,   // joining the two roots by rank
    KMST_RANK,   // bumping the rank of the surviving root
    KMST_DONE    // handing the result to the output register
  } kmst_state_e;

endpackage

/* rtl/kmst_in_if.sv */
// Input channel of the union-find engine: valid/ready handshake with one edge or clear item.
// Depends on kmst_pkg for the field widths.
interface kmst_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [kmst_pkg::NodeW-1:0]  node_a;
  logic [kmst_pkg::NodeW-1:0]  node_b;
  logic [kmst_pkg::CostW-1:0]  edge_cost;

  modport source (output valid, action, node_a, node_b, edge_cost, input ready);
  modport sink   (input valid, action, node_a, node_b, edge_cost, output ready);
endinterface

/* rtl/kmst_out_if.sv */
// Output channel of the union-find engine: valid/ready handshake with one result item.
// Depends on kmst_pkg for the field widths.
interface kmst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          edge_taken;
  logic [kmst_pkg::WeightW-1:0]  tree_weight;
  logic                          all_connected;

  modport source (output valid, edge_taken, tree_weight, all_connected, input ready);
  modport sink   (input valid, edge_taken, tree_weight, all_connected, output ready);
endinterface

/* rtl/kruskal_union_find_mst_top.sv */
// Top level of the union-find engine for Kruskal's minimum spanning tree.
// Depends on kmst_pkg, kmst_in_if and kmst_out_if.
//
//   Channel   Direction  Handshake           Carries
//   item_i    in         valid/ready         action, node_a, node_b, edge_cost
//   res_o     out        valid/ready         edge_taken, tree_weight, all_connected
//   cfg       in         cfg_we_i only       cfg_wdata_i = node count, used at the next clear
//
// An edge walks the parent chain from each endpoint to its root through the single read
// port, once to find the root and once to compress the path, and adds a rank update when
// two roots of equal rank below the maximum are joined. An edge with an unused endpoint
// goes straight to its result; a clear writes one memory word per latched node.
// After reset a one-entry clearing pass runs before the first input transfer is taken.
// A waiting result does not block the next transfer; an item stalls at its end while it waits.

module kruskal_union_find_mst_top #(
  parameter int unsigned MaxNodes = kmst_pkg::MaxNodesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  kmst_in_if.sink                             item_i,
  kmst_out_if.source                          res_o,
  input  logic                                cfg_we_i,
  input  logic [kmst_pkg::NodeCountW-1:0]     cfg_wdata_i
);

  // Only the nodes below the lower of MaxNodes and the endpoint range are ever touched.
  localparam int unsigned Depth = (MaxNodes < kmst_pkg::MaxUsedNodes) ?
                                  MaxNodes : kmst_pkg::MaxUsedNodes;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [kmst_pkg::NodeCountW-1:0] CountTop = kmst_pkg::NodeCountW'(Depth);
  localparam logic [kmst_pkg::RankW-1:0]      RankMax  = '1;

  // One memory word holds both the parent link and the rank of a node.
  typedef struct packed {
    logic [kmst_pkg::RankW-1:0] rank;
    logic [AW-1:0]              parent;
  } node_word_t;

  // Node count as latched at a clear: zero means one, large values saturate.
  function automatic logic [kmst_pkg::NodeCountW-1:0] clamp_count(
    input logic [kmst_pkg::NodeCountW-1:0] v
  );
    logic [kmst_pkg::NodeCountW-1:0] r;
    r = v;
    if (v == '0) begin
      r = kmst_pkg::NodeCountW'(1);
    end else if (v > CountTop) begin
      r = CountTop;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  kmst_pkg::kmst_state_e state_q, state_d;

  logic [kmst_pkg::NodeCountW-1:0] node_count_q, node_count_d;    // configuration
  logic [kmst_pkg::NodeCountW-1:0] nodes_active_q, nodes_active_d; // latched at clear
  logic [kmst_pkg::NodeCountW-1:0] comps_q, comps_d;               // components left
  logic [kmst_pkg::WeightW-1:0]    weight_q, weight_d;             // tree weight total
  logic                            taken_q, taken_d;

  logic [AW-1:0]                   clr_idx_q, clr_idx_d;
  logic [AW-1:0]                   cur_q, cur_d;      // node whose word is being read
  logic                            side_q, side_d;    // 0 while on node_a, 1 on node_b
  logic [AW-1:0]                   ra_q, ra_d;        // root of node_a
  logic [AW-1:0]                   rb_q, rb_d;        // root of node_b
  logic [kmst_pkg::RankW-1:0]      rank_a_q, rank_a_d;
  logic [kmst_pkg::RankW-1:0]      rank_b_q, rank_b_d;

  logic [AW-1:0]                   node_a_q, node_a_d;
  logic [AW-1:0]                   node_b_q, node_b_d;
  logic [kmst_pkg::CostW-1:0]      cost_q, cost_d;

  logic                            out_valid_q, out_valid_d;
  logic                            out_taken_q, out_taken_d;
  logic [kmst_pkg::WeightW-1:0]    out_weight_q, out_weight_d;
  logic                            out_conn_q, out_conn_d;

  // Node memory with a registered read port.
  node_word_t                      node_mem [Depth];
  node_word_t                      rd_word_q;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  node_word_t                      wr_data;

  // ---------------------------------------------------------------------------
  // Helper signals
  // ---------------------------------------------------------------------------
  logic                            in_xfer;
  logic                            out_free;
  logic                            edge_ok;
  logic [AW-1:0]                   clr_last;
  logic [AW-1:0]                   start_node;
  logic [AW-1:0]                   side_root;
  logic [kmst_pkg::WeightW:0]      weight_sum;

  assign in_xfer    = item_i.valid && item_i.ready;
  assign out_free   = !out_valid_q || res_o.ready;
  assign edge_ok    = ({1'b0, item_i.node_a} < nodes_active_q) &&
                      ({1'b0, item_i.node_b} < nodes_active_q);
  assign clr_last   = AW'(nodes_active_q - kmst_pkg::NodeCountW'(1));
  assign start_node = side_q ? node_b_q : node_a_q;
  assign side_root  = side_q ? rb_q : ra_q;
  assign weight_sum = {1'b0, weight_q} + (kmst_pkg::WeightW + 1)'(cost_q);

  assign item_i.ready      = (state_q == kmst_pkg::KMST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.edge_taken  = out_taken_q;
  assign res_o.tree_weight = out_weight_q;
  assign res_o.all_connected = out_conn_q;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmst_pkg::KMST_INIT: begin
        if (clr_idx_q == clr_last) begin
          state_d = kmst_pkg::KMST_IDLE;
        end
      end
      kmst_pkg::KMST_IDLE: begin
        if (in_xfer) begin
          if (item_i.action == kmst_pkg::ActClear) begin
            state_d = kmst_pkg::KMST_CLEAR;
          end else if (edge_ok) begin
            state_d = kmst_pkg::KMST_FIND;
          end else begin
            state_d = kmst_pkg::KMST_DONE;
          end
        end
      end
      kmst_pkg::KMST_CLEAR: begin
        if (clr_idx_q == clr_last) begin
          state_d = kmst_pkg::KMST_DONE;
        end
      end
      kmst_pkg::KMST_FIND: begin
        if (rd_word_q.parent == cur_q) begin
          state_d = (start_node == cur_q) ? kmst_pkg::KMST_NEXT : kmst_pkg::KMST_COMP;
        end
      end
      kmst_pkg::KMST_COMP: begin
        if (rd_word_q.parent == side_root) begin
          state_d = kmst_pkg::KMST_NEXT;
        end
      end
      kmst_pkg::KMST_NEXT: begin
        state_d = side_q ? kmst_pkg::KMST_LINK : kmst_pkg::KMST_FIND;
      end
      kmst_pkg::KMST_LINK: begin
        if ((ra_q != rb_q) && (rank_a_q == rank_b_q) && (rank_a_q != RankMax)) begin
          state_d = kmst_pkg::KMST_RANK;
        end else begin
          state_d = kmst_pkg::KMST_DONE;
        end
      end
      kmst_pkg::KMST_RANK: begin
        state_d = kmst_pkg::KMST_DONE;
      end
      kmst_pkg::KMST_DONE: begin
        if (out_free) begin
          state_d = kmst_pkg::KMST_IDLE;
        end
      end
      default: begin
        state_d = kmst_pkg::KMST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory accesses and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_en          = 1'b0;
    rd_addr        = cur_q;
    wr_en          = 1'b0;
    wr_addr        = cur_q;
    wr_data        = '{rank: rd_word_q.rank, parent: side_root};

    node_count_d   = cfg_we_i ? cfg_wdata_i : node_count_q;
    nodes_active_d = nodes_active_q;
    comps_d        = comps_q;
    weight_d       = weight_q;
    taken_d        = taken_q;
    clr_idx_d      = clr_idx_q;
    cur_d          = cur_q;
    side_d         = side_q;
    ra_d           = ra_q;
    rb_d           = rb_q;
    rank_a_d       = rank_a_q;
    rank_b_d       = rank_b_q;
    node_a_d       = node_a_q;
    node_b_d       = node_b_q;
    cost_d         = cost_q;

    out_valid_d    = out_valid_q && !res_o.ready;
    out_taken_d    = out_taken_q;
    out_weight_d   = out_weight_q;
    out_conn_d     = out_conn_q;

    unique case (state_q)
      kmst_pkg::KMST_INIT,
      kmst_pkg::KMST_CLEAR: begin
        // Each node becomes its own root with rank zero.
        wr_en     = 1'b1;
        wr_addr   = clr_idx_q;
        wr_data   = '{rank: '0, parent: clr_idx_q};
        clr_idx_d = clr_idx_q + AW'(1);
      end
      kmst_pkg::KMST_IDLE: begin
        if (in_xfer) begin
          taken_d  = 1'b0;
          side_d   = 1'b0;
          node_a_d = AW'(item_i.node_a);
          node_b_d = AW'(item_i.node_b);
          cost_d   = item_i.edge_cost;
          if (item_i.action == kmst_pkg::ActClear) begin
            nodes_active_d = clamp_count(node_count_q);
            comps_d        = clamp_count(node_count_q);
            weight_d       = '0;
            clr_idx_d      = '0;
          end else if (edge_ok) begin
            rd_en   = 1'b1;
            rd_addr = AW'(item_i.node_a);
            cur_d   = AW'(item_i.node_a);
          end
        end
      end
      kmst_pkg::KMST_FIND: begin
        if (rd_word_q.parent == cur_q) begin
          // Root reached: remember it, then restart at the endpoint to compress.
          if (side_q) begin
            rb_d     = cur_q;
            rank_b_d = rd_word_q.rank;
          end else begin
            ra_d     = cur_q;
            rank_a_d = rd_word_q.rank;
          end
          cur_d = start_node;
          if (start_node != cur_q) begin
            rd_en   = 1'b1;
            rd_addr = start_node;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_word_q.parent;
          cur_d   = rd_word_q.parent;
        end
      end
      kmst_pkg::KMST_COMP: begin
        // Point the current node straight at the root; read its old parent next.
        wr_en   = 1'b1;
        wr_addr = cur_q;
        wr_data = '{rank: rd_word_q.rank, parent: side_root};
        if (rd_word_q.parent != side_root) begin
          rd_en   = 1'b1;
          rd_addr = rd_word_q.parent;
          cur_d   = rd_word_q.parent;
        end
      end
      kmst_pkg::KMST_NEXT: begin
        // For node_a, the read of node_b is issued here, once the compression writes are done.
        if (!side_q) begin
          side_d  = 1'b1;
          rd_en   = 1'b1;
          rd_addr = node_b_q;
          cur_d   = node_b_q;
        end
      end
      kmst_pkg::KMST_LINK: begin
        if (ra_q != rb_q) begin
          wr_en = 1'b1;
          if (rank_a_q >= rank_b_q) begin
            wr_addr = rb_q;
            wr_data = '{rank: rank_b_q, parent: ra_q};
          end else begin
            wr_addr = ra_q;
            wr_data = '{rank: rank_a_q, parent: rb_q};
          end
          weight_d = weight_sum[kmst_pkg::WeightW] ? '1 : weight_sum[kmst_pkg::WeightW-1:0];
          if (comps_q > kmst_pkg::NodeCountW'(1)) begin
            comps_d = comps_q - kmst_pkg::NodeCountW'(1);
          end
          taken_d = 1'b1;
        end
      end
      kmst_pkg::KMST_RANK: begin
        wr_en   = 1'b1;
        wr_addr = ra_q;
        wr_data = '{rank: rank_a_q + kmst_pkg::RankW'(1), parent: ra_q};
      end
      kmst_pkg::KMST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_taken_d  = taken_q;
          out_weight_d = weight_q;
          out_conn_d   = (comps_q == kmst_pkg::NodeCountW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Node memory
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_word_q <= node_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= kmst_pkg::KMST_INIT;
      node_count_q   <= kmst_pkg::NodeCountW'(1);
      nodes_active_q <= kmst_pkg::NodeCountW'(1);
      comps_q        <= kmst_pkg::NodeCountW'(1);
      weight_q       <= '0;
      taken_q        <= 1'b0;
      clr_idx_q      <= '0;
      side_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      node_count_q   <= node_count_d;
      nodes_active_q <= nodes_active_d;
      comps_q        <= comps_d;
      weight_q       <= weight_d;
      taken_q        <= taken_d;
      clr_idx_q      <= clr_idx_d;
      side_q         <= side_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    rank_a_q     <= rank_a_d;
    rank_b_q     <= rank_b_d;
    node_a_q     <= node_a_d;
    node_b_q     <= node_b_d;
    cost_q       <= cost_d;
    out_taken_q  <= out_taken_d;
    out_weight_q <= out_weight_d;
    out_conn_q   <= out_conn_d;
  end

endmodule

/* verif/kruskal_union_find_mst_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for kruskal_union_find_mst_top: a directed table, then random phases.
// Depends on kmst_pkg, kmst_in_if, kmst_out_if and the RTL top; it reads nothing else.
module kruskal_union_find_mst_top_tb;
  import kmst_pkg::*;

  // One item as it travels on the input channel.
  typedef struct packed {
    logic               action;
    logic [NodeW-1:0]   node_a;
    logic [NodeW-1:0]   node_b;
    logic [CostW-1:0]   edge_cost;
  } edge_item_t;

  // One result as it comes back on the output channel.
  typedef struct packed {
    logic               edge_taken;
    logic [WeightW-1:0] tree_weight;
    logic               all_connected;
  } mst_result_t;

  // A row of the directed table. A row may first write the node count; that
  // write happens only once every earlier result has come back. Where typed is
  // set, the expected result is the one written in the row; otherwise it comes
  // from the union-find predictor below.
  typedef struct {
    bit                    cfg_we;
    logic [NodeCountW-1:0] cfg_val;
    logic                  act;
    logic [NodeW-1:0]      a;
    logic [NodeW-1:0]      b;
    logic [CostW-1:0]      cost;
    bit                    typed;
    logic                  taken;
    logic [WeightW-1:0]    weight;
    logic                  conn;
  } plan_row_t;

  localparam int PlanRows = 23;
  localparam int RandomWork = 2000;
  localparam int MaxGap = 10;
  localparam int ExpDepth = 16;

  plan_row_t plan [PlanRows] = '{
    // Reset leaves a single node: a self loop on it is not taken, one component.
    '{1'b0, 11'd0,    ActEdge,  10'd0,    10'd0,    16'd0,     1'b1, 1'b0, 32'd0,     1'b1},
    // Endpoints beyond the single active node are ignored.
    '{1'b0, 11'd0,    ActEdge,  10'd1023, 10'd1023, 16'd65535, 1'b1, 1'b0, 32'd0,     1'b1},
    '{1'b0, 11'd0,    ActClear, 10'd0,    10'd0,    16'd0,     1'b1, 1'b0, 32'd0,     1'b1},
    // A node count of zero is taken as one; the clear ignores the edge fields.
    '{1'b1, 11'd0,    ActClear, 10'd1023, 10'd1023, 16'd65535, 1'b1, 1'b0, 32'd0,     1'b1},
    '{1'b1, 11'd4,    ActClear, 10'd0,    10'd0,    16'd0,     1'b1, 1'b0, 32'd0,     1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd0,    10'd1,    16'd0,     1'b1, 1'b1, 32'd0,     1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd2,    10'd3,    16'd5,     1'b1, 1'b1, 32'd5,     1'b0},
    // Same component, then a self loop, then an endpoint equal to the count.
    '{1'b0, 11'd0,    ActEdge,  10'd1,    10'd0,    16'd5,     1'b1, 1'b0, 32'd5,     1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd3,    10'd3,    16'd7,     1'b1, 1'b0, 32'd5,     1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd0,    10'd4,    16'd7,     1'b1, 1'b0, 32'd5,     1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd1,    10'd2,    16'd65535, 1'b1, 1'b1, 32'd65540, 1'b1},
    '{1'b0, 11'd0,    ActEdge,  10'd0,    10'd3,    16'd65535, 1'b1, 1'b0, 32'd65540, 1'b1},
    // A new count does not apply before the next clear, so node 1023 is still unused.
    '{1'b1, 11'd2047, ActEdge,  10'd1023, 10'd0,    16'd65535, 1'b1, 1'b0, 32'd65540, 1'b1},
    '{1'b0, 11'd0,    ActClear, 10'd0,    10'd0,    16'd0,     1'b1, 1'b0, 32'd0,     1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd1023, 10'd0,    16'd65535, 1'b1, 1'b1, 32'd65535, 1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd512,  10'd1023, 16'd65535, 1'b0, 1'b0, 32'd0,     1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd0,    10'd512,  16'd65535, 1'b0, 1'b0, 32'd0,     1'b0},
    '{1'b1, 11'd1024, ActClear, 10'd0,    10'd0,    16'd0,     1'b1, 1'b0, 32'd0,     1'b0},
    '{1'b1, 11'd1025, ActClear, 10'd0,    10'd0,    16'd0,     1'b1, 1'b0, 32'd0,     1'b0},
    '{1'b1, 11'd2,    ActClear, 10'd0,    10'd0,    16'd0,     1'b1, 1'b0, 32'd0,     1'b0},
    '{1'b0, 11'd0,    ActEdge,  10'd1,    10'd0,    16'd0,     1'b1, 1'b1, 32'd0,     1'b1},
    '{1'b0, 11'd0,    ActEdge,  10'd0,    10'd1,    16'd65535, 1'b1, 1'b0, 32'd0,     1'b1},
    '{1'b1, 11'd1,    ActClear, 10'd0,    10'd0,    16'd0,     1'b1, 1'b0, 32'd0,     1'b1}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [NodeCountW-1:0] cfg_wdata_i;

  kmst_in_if  item_if ();
  kmst_out_if res_if ();

  kruskal_union_find_mst_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the forest. link_of is the parent pointer of each node.
  logic [NodeW-1:0]      link_of [MaxUsedNodes];
  logic [RankW-1:0]      rank_tbl [MaxUsedNodes];
  logic [WeightW-1:0]    weight_sum;
  logic [NodeCountW-1:0] comps_left;
  logic [NodeCountW-1:0] active_nodes;
  logic [NodeCountW-1:0] count_reg;

  // Expected results in transfer order, kept in a ring; head and tail count
  // the entries taken out and put in.
  mst_result_t exp_ring [ExpDepth];
  int          exp_head;
  int          exp_tail;

  int  mismatches;
  int  items_sent;
  int  clears_sent;
  int  results_checked;
  int  taken_seen;
  int  connected_seen;
  int  phases_run;
  bit  src_burst;
  bit  sink_burst;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The count register is clamped into 1..1024 when a clear latches it.
  function automatic logic [NodeCountW-1:0] clamp_nodes(input logic [NodeCountW-1:0] v);
    if (v == '0) return NodeCountW'(1);
    if (v > MaxUsedNodes) return NodeCountW'(MaxUsedNodes);
    return v;
  endfunction

  function automatic void rebuild_forest();
    for (int i = 0; i < MaxUsedNodes; i++) begin
      link_of[i]  = NodeW'(i);
      rank_tbl[i] = '0;
    end
    weight_sum   = '0;
    active_nodes = clamp_nodes(count_reg);
    comps_left   = active_nodes;
  endfunction

  // Root lookup with full path compression: a first walk finds the root, a
  // second one points every node on the path straight at it.
  function automatic logic [NodeW-1:0] find_set(input logic [NodeW-1:0] x);
    logic [NodeW-1:0] r;
    logic [NodeW-1:0] nxt;
    r = x;
    while (link_of[r] != r) r = link_of[r];
    while (x != r) begin
      nxt = link_of[x];
      link_of[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  // Expected result of one accepted item, updating the shadow forest.
  function automatic mst_result_t mst_predict(input edge_item_t it);
    mst_result_t res;
    logic [NodeW-1:0] ra;
    logic [NodeW-1:0] rb;
    res.edge_taken = 1'b0;
    if (it.action == ActClear) begin
      rebuild_forest();
    end else if (it.node_a < active_nodes && it.node_b < active_nodes) begin
      ra = find_set(it.node_a);
      rb = find_set(it.node_b);
      if (ra != rb) begin
        // Union by rank; the rank grows only when both trees are equally tall.
        if (rank_tbl[ra] >= rank_tbl[rb]) begin
          if (rank_tbl[ra] == rank_tbl[rb] && rank_tbl[ra] != '1) rank_tbl[ra]++;
          link_of[rb] = ra;
        end else begin
          link_of[ra] = rb;
        end
        if (weight_sum > {WeightW{1'b1}} - WeightW'(it.edge_cost)) weight_sum = '1;
        else weight_sum = weight_sum + WeightW'(it.edge_cost);
        if (comps_left > 1) comps_left--;
        res.edge_taken = 1'b1;
      end
    end
    res.tree_weight   = weight_sum;
    res.all_connected = (comps_left == 1);
    return res;
  endfunction

  // Sends one item after a random gap and records its expected result at the
  // edge of the transfer. If the gap is zero, valid simply stays high and only
  // the payload changes, so valid never sees two assignments in one step.
  task automatic push_item(input edge_item_t it, input bit typed, input mst_result_t want);
    int gap;
    mst_result_t guess;
    gap = src_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.action    <= it.action;
    item_if.node_a    <= it.node_a;
    item_if.node_b    <= it.node_b;
    item_if.edge_cost <= it.edge_cost;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    guess = mst_predict(it);
    exp_ring[exp_tail % ExpDepth] = typed ? want : guess;
    exp_tail++;
    items_sent++;
    if (it.action == ActClear) clears_sent++;
  endtask

  // Writes the node count once the engine has returned every result. It is
  // called right after a transfer, so lowering valid here is the only
  // assignment to valid in that step.
  task automatic set_node_count(input logic [NodeCountW-1:0] v);
    item_if.valid <= 1'b0;
    wait (exp_tail == exp_head);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    count_reg = v;
  endtask

  // Result side: random stalls of ready, with stretches of none, and a check of
  // every result transfer against the oldest expectation.
  initial begin
    int stall;
    mst_result_t want;
    res_if.ready = 1'b0;
    sink_burst   = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = ~sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      results_checked++;
      if (exp_tail == exp_head) begin
        $error("result transfer with nothing expected: taken %0b weight %0d connected %0b",
               res_if.edge_taken, res_if.tree_weight, res_if.all_connected);
        mismatches++;
      end else begin
        want = exp_ring[exp_head % ExpDepth];
        exp_head++;
        if (res_if.edge_taken !== want.edge_taken) begin
          $error("edge_taken: expected %0b, got %0b", want.edge_taken, res_if.edge_taken);
          mismatches++;
        end
        if (res_if.tree_weight !== want.tree_weight) begin
          $error("tree_weight: expected %0d, got %0d", want.tree_weight, res_if.tree_weight);
          mismatches++;
        end
        if (res_if.all_connected !== want.all_connected) begin
          $error("all_connected: expected %0b, got %0b", want.all_connected,
                 res_if.all_connected);
          mismatches++;
        end
        if (want.edge_taken) taken_seen++;
        if (want.all_connected) connected_seen++;
      end
    end
  end

  // Main stimulus: reset, the directed table, then random phases. Each phase
  // writes a node count while the engine is idle, clears the forest and feeds
  // mostly well-formed edges in nondecreasing cost, mixed with unused endpoints,
  // out-of-order costs and the occasional clear in the middle of a phase.
  initial begin
    edge_item_t it;
    mst_result_t want;
    mst_result_t none;
    logic [NodeCountW-1:0] nc;
    int work_done;
    int big_phases;
    int n_edges;
    int kind;
    int pick;
    int cost_run;
    int act;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    item_if.valid     = 1'b0;
    item_if.action    = ActClear;
    item_if.node_a    = '0;
    item_if.node_b    = '0;
    item_if.edge_cost = '0;
    none              = '0;
    src_burst         = 1'b0;
    exp_head          = 0;
    exp_tail          = 0;
    mismatches        = 0;
    items_sent        = 0;
    clears_sent       = 0;
    results_checked   = 0;
    taken_seen        = 0;
    connected_seen    = 0;
    phases_run        = 0;
    count_reg         = NodeCountW'(1);
    rebuild_forest();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, every action and each corner case.
    for (int i = 0; i < PlanRows; i++) begin
      if (plan[i].cfg_we) set_node_count(plan[i].cfg_val);
      it   = '{plan[i].act, plan[i].a, plan[i].b, plan[i].cost};
      want = '{plan[i].taken, plan[i].weight, plan[i].conn};
      push_item(it, plan[i].typed, want);
    end

    // Random phases. Ignored edges do not count toward the amount of work.
    work_done  = 0;
    big_phases = 0;
    while (work_done < RandomWork) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        nc = '0;
      end else if (pick < 8) begin
        nc = NodeCountW'(1);
      end else if (pick < 12 && big_phases < 3) begin
        big_phases++;
        nc = $urandom_range(0, 1) ? NodeCountW'(MaxUsedNodes)
                                  : NodeCountW'($urandom_range(MaxUsedNodes + 1, 2047));
      end else begin
        nc = NodeCountW'($urandom_range(2, 48));
      end
      set_node_count(nc);
      src_burst = ($urandom_range(0, 5) == 0);
      phases_run++;

      // The clear carries random edge fields, which it must ignore.
      it = '{ActClear, NodeW'($urandom), NodeW'($urandom), CostW'($urandom)};
      push_item(it, 1'b0, none);
      work_done++;

      act      = active_nodes;
      n_edges  = (act == MaxUsedNodes) ? 400 : act * 2 + $urandom_range(0, 12);
      cost_run = ($urandom_range(0, 3) == 0) ? $urandom_range(60000, 65535)
                                             : $urandom_range(0, 2000);
      for (int e = 0; e < n_edges && work_done < RandomWork; e++) begin
        kind = $urandom_range(0, 99);
        it.action = ActEdge;
        if (kind < 84) begin
          cost_run += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 5000)
                                                   : $urandom_range(0, 4);
          if (cost_run > 65535) cost_run = 65535;
          it.node_a    = NodeW'($urandom_range(0, act - 1));
          it.node_b    = NodeW'($urandom_range(0, act - 1));
          it.edge_cost = CostW'(cost_run);
        end else if (kind < 92) begin
          it.node_a    = NodeW'($urandom);
          it.node_b    = NodeW'($urandom);
          it.edge_cost = CostW'($urandom);
        end else if (kind < 97) begin
          it.node_a    = NodeW'($urandom_range(0, act - 1));
          it.node_b    = NodeW'($urandom_range(0, act - 1));
          it.edge_cost = CostW'($urandom);
        end else begin
          it = '{ActClear, NodeW'($urandom), NodeW'($urandom), CostW'($urandom)};
        end
        if (it.action == ActClear || (it.node_a < active_nodes && it.node_b < active_nodes))
          work_done++;
        push_item(it, 1'b0, none);
      end
    end

    // Drain: lower valid, wait for the last result, then idle a little longer
    // so that a stray extra result would still be caught.
    item_if.valid <= 1'b0;
    wait (exp_tail == exp_head);
    repeat (64) @(posedge clk_i);

    $display("Sent %0d transfers over %0d random phases, %0d of them clears.",
             items_sent, phases_run, clears_sent);
    $display("Checked %0d results: %0d edges joined trees, %0d showed a single component.",
             results_checked, taken_seen, connected_seen);
    if (mismatches == 0) begin
      $display("kruskal_union_find_mst_top regression: pass");
    end else begin
      $display("kruskal_union_find_mst_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including full-size clears.
  initial begin
    #20_000_000;
    $display("kruskal_union_find_mst_top regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/kmst_pkg.sv
rtl/kmst_in_if.sv
rtl/kmst_out_if.sv
rtl/kruskal_union_find_mst_top.sv
verif/kruskal_union_find_mst_top_tb.sv
